>>> sv/osmpd_pkg.sv
// Shared types and constants for the ordered selection max product block.
`default_nettype none
package osmpd_pkg;

    localparam int ELEM_W  = 16;
    localparam int SUM_W   = 38;
    localparam int PROD_W  = 32;
    localparam int POS_W   = 8;
    localparam int SLOT_W  = 6;
    localparam int NCFG_W  = 9;
    localparam int MCFG_W  = 7;

    typedef enum logic [1:0] {
        OP_LOAD_VAL  = 2'd0,
        OP_LOAD_COEF = 2'd1,
        OP_SOLVE     = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic {
        CFG_VALUES_USED = 1'b0,
        CFG_COEFS_USED  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_TB_RD,
        ST_TB_CHK,
        ST_FILL,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } t_state;

endpackage
`default_nettype wire

>>> sv/ordered_selection_max_product_dp_top.sv
// Top level: ordered selection with maximum weighted sum, systolic row of cells.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | i_valid / o_ready    | i_operation, i_position, i_element
//  out     | output    | o_valid / i_ready    | o_best_sum, o_slot, o_chosen_position,
//          |           |                      | o_feasible, o_last
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// Loads write the value RAM or a coefficient register when accepted. A solve feeds
// the cell row (one value enters the first cell each cycle, one cell per coefficient),
// then walks the take-bit memories in ST_TB_RD/ST_TB_CHK steps (at most n), then ST_FILL,
// then ST_EM_RD, ST_EM_LD, ST_EM_WAIT per result plus output stalls. One beat is in flight at a time.
// Synchronous active-low reset; no clearing pass is needed.
`default_nettype none
module ordered_selection_max_product_dp_top
    import osmpd_pkg::*;
#(
    parameter int MAX_VALUES       = 256,
    parameter int MAX_COEFFICIENTS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_index,
    input  wire logic [NCFG_W-1:0]        i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_operation,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [ELEM_W-1:0] i_element,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [SUM_W-1:0]       o_best_sum,
    output logic [SLOT_W-1:0]             o_slot,
    output logic [POS_W-1:0]              o_chosen_position,
    output logic                          o_feasible,
    output logic                          o_last
);
    localparam int VW = $clog2(MAX_VALUES);
    localparam int NW = $clog2(MAX_VALUES + 1);
    localparam int MW = $clog2(MAX_COEFFICIENTS + 1);
    localparam int CW = (MAX_COEFFICIENTS > 1) ? $clog2(MAX_COEFFICIENTS) : 1;
    localparam int CD = (MAX_COEFFICIENTS > 1) ? MAX_COEFFICIENTS : 2;

    t_state r_state, n_state;

    logic [NCFG_W-1:0] r_values_used;
    logic [MCFG_W-1:0] r_coefs_used;
    logic [NW-1:0]     w_n;
    logic [MW-1:0]     w_m;
    logic              w_infeas;
    logic [NW-1:0]     w_span;

    logic [VW-1:0]           r_j;
    logic                    r_feed_v;
    logic [VW-1:0]           r_feed_j;
    logic signed [SUM_W-1:0] r_best;
    logic [MW-1:0]           r_ta;
    logic [NW-1:0]           r_tb;
    logic [MW-1:0]           r_k;

    logic                    w_accept;
    t_op                     w_op;
    logic                    w_val_we;
    logic                    w_coef_we;
    logic signed [ELEM_W-1:0] w_val_rd;

    logic                    w_cv   [MAX_COEFFICIENTS+1];
    logic [VW-1:0]           w_ci   [MAX_COEFFICIENTS+1];
    logic signed [ELEM_W-1:0] w_cx  [MAX_COEFFICIENTS+1];
    logic signed [SUM_W-1:0] w_cd   [MAX_COEFFICIENTS+1];
    logic signed [SUM_W-1:0] w_score [MAX_COEFFICIENTS];
    logic [CD-1:0]           w_take;

    logic [CW-1:0]           w_last_cell;
    logic                    w_cap;
    logic [VW-1:0]           w_tb_addr;
    logic                    w_take_sel;
    logic [MW-1:0]           w_ta_next;
    logic [NW-1:0]           w_tb_next;
    logic                    w_tb_more;

    logic                    w_pk_we;
    logic [CW-1:0]           w_pk_waddr;
    logic [VW-1:0]           w_pk_wdata;
    logic [VW-1:0]           w_pk_rdata;

    assign w_op     = t_op'(i_operation);
    assign w_accept = i_valid && o_ready;

    assign w_n      = (32'(r_values_used) > MAX_VALUES) ? NW'(MAX_VALUES) : NW'(r_values_used);
    assign w_m      = (32'(r_coefs_used) > MAX_COEFFICIENTS) ?
                      MW'(MAX_COEFFICIENTS) : MW'(r_coefs_used);
    assign w_infeas = 32'(w_m) > 32'(w_n);
    assign w_span   = NW'(32'(w_n) - 32'(w_m));

    assign w_val_we  = w_accept && (w_op == OP_LOAD_VAL) && (32'(i_position) < MAX_VALUES);
    assign w_coef_we = w_accept && (w_op == OP_LOAD_COEF);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_values_used <= NCFG_W'(1);
            r_coefs_used  <= MCFG_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VALUES_USED: r_values_used <= i_cfg_data;
                CFG_COEFS_USED:  r_coefs_used  <= i_cfg_data[MCFG_W-1:0];
                default: ;
            endcase
        end
    end

    osmpd_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_VALUES)) u_values (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (VW'(i_position)),
        .i_wdata (i_element),
        .i_raddr (r_j),
        .o_rdata (w_val_rd)
    );

    assign w_cv[0] = r_feed_v;
    assign w_ci[0] = r_feed_j;
    assign w_cx[0] = w_val_rd;
    assign w_cd[0] = '0;

    for (genvar g = 0; g < MAX_COEFFICIENTS; g++) begin : g_cell
        osmpd_cell #(.MAX_VALUES(MAX_VALUES), .K(g), .VW(VW), .NW(NW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_coef_we  (w_coef_we),
            .i_coef_pos (i_position),
            .i_coef     (i_element),
            .i_span     (w_span),
            .i_valid    (w_cv[g]),
            .i_idx      (w_ci[g]),
            .i_val      (w_cx[g]),
            .i_diag     (w_cd[g]),
            .o_valid    (w_cv[g+1]),
            .o_idx      (w_ci[g+1]),
            .o_val      (w_cx[g+1]),
            .o_diag     (w_cd[g+1]),
            .o_score    (w_score[g]),
            .i_tb_addr  (w_tb_addr),
            .o_take     (w_take[g])
        );
    end
    if (CD > MAX_COEFFICIENTS) begin : g_pad
        assign w_take[CD-1] = 1'b0;
    end

    osmpd_ram #(.WIDTH(VW), .DEPTH(CD)) u_picks (
        .i_clk   (i_clk),
        .i_we    (w_pk_we),
        .i_waddr (w_pk_waddr),
        .i_wdata (w_pk_wdata),
        .i_raddr (r_k[CW-1:0]),
        .o_rdata (w_pk_rdata)
    );

    // final score leaves the last used cell with the last value index
    assign w_last_cell = CW'(w_m - 1'b1);
    assign w_cap       = (r_state == ST_DRAIN) && w_cv[32'(w_last_cell) + 1] &&
                         (w_ci[32'(w_last_cell) + 1] == VW'(w_n - 1'b1));

    assign w_tb_addr  = VW'(r_tb - 1'b1);
    assign w_take_sel = w_take[CW'(r_ta - 1'b1)];
    assign w_ta_next  = w_take_sel ? (r_ta - 1'b1) : r_ta;
    assign w_tb_next  = r_tb - 1'b1;
    assign w_tb_more  = (w_ta_next != '0) && (w_tb_next != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_SOLVE)) begin
                    n_state = (w_infeas || (w_m == '0)) ? ST_EM_WAIT : ST_FEED;
                end
            end
            ST_FEED: begin
                if (r_j == VW'(w_n - 1'b1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_cap) begin
                    n_state = ST_TB_RD;
                end
            end
            ST_TB_RD:  n_state = ST_TB_CHK;
            ST_TB_CHK: begin
                if (w_tb_more) begin
                    n_state = ST_TB_RD;
                end else if (w_ta_next != '0) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_EM_RD;
                end
            end
            ST_FILL: begin
                if (r_ta == MW'(1)) begin
                    n_state = ST_EM_RD;
                end
            end
            ST_EM_RD: n_state = ST_EM_LD;
            ST_EM_LD: n_state = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (i_ready) begin
                    n_state = o_last ? ST_IDLE : ST_EM_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        w_pk_we    = 1'b0;
        w_pk_waddr = CW'(r_ta - 1'b1);
        w_pk_wdata = '0;
        case (r_state)
            ST_TB_CHK: begin
                w_pk_we    = w_take_sel;
                w_pk_wdata = VW'(r_tb - 1'b1);
            end
            ST_FILL: w_pk_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_feed_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_feed_v <= (r_state == ST_FEED);
            if (r_state == ST_IDLE && w_accept && (w_op == OP_SOLVE) &&
                (w_infeas || (w_m == '0))) begin
                o_valid <= 1'b1;
            end else if (r_state == ST_EM_LD) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
        end

        r_feed_j <= r_j;
        case (r_state)
            ST_IDLE: begin
                r_j  <= '0;
                r_k  <= '0;
                r_ta <= w_m;
                r_tb <= w_n;
                o_best_sum        <= '0;
                o_slot            <= '0;
                o_chosen_position <= '0;
                o_feasible        <= !w_infeas;
                o_last            <= 1'b1;
            end
            ST_FEED:   r_j <= r_j + 1'b1;
            ST_DRAIN: begin
                if (w_cap) begin
                    r_best <= w_score[w_last_cell];
                end
            end
            ST_TB_CHK: begin
                r_ta <= w_ta_next;
                r_tb <= w_tb_next;
            end
            ST_FILL:   r_ta <= r_ta - 1'b1;
            ST_EM_LD: begin
                o_best_sum        <= r_best;
                o_slot            <= SLOT_W'(r_k);
                o_chosen_position <= POS_W'(w_pk_rdata);
                o_feasible        <= 1'b1;
                o_last            <= (r_k == w_m - 1'b1);
            end
            ST_EM_WAIT: begin
                if (i_ready) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_out_only_when_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_EM_WAIT))
        else $error("result beat outside emit");

    a_infeasible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_feasible) |-> (o_best_sum == '0 && o_last))
        else $error("infeasible beat carries data");

    a_tb_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TB_CHK) |-> (r_ta != '0 && r_tb != '0 && r_ta <= w_m))
        else $error("traceback indexes out of range");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_feasible && w_m != '0) |-> (32'(o_slot) < 32'(w_m)))
        else $error("slot beyond coefficient count");
`endif
endmodule
`default_nettype wire

>>> sv/osmpd_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module osmpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/osmpd_cell.sv
// One coefficient row of the grid: multiply-add-compare, take-bit memory.
`default_nettype none
module osmpd_cell
    import osmpd_pkg::*;
#(
    parameter int MAX_VALUES = 256,
    parameter int K          = 0,
    parameter int VW         = 8,
    parameter int NW         = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_coef_we,
    input  wire logic [POS_W-1:0]         i_coef_pos,
    input  wire logic signed [ELEM_W-1:0] i_coef,
    input  wire logic [NW-1:0]            i_span,
    input  wire logic                     i_valid,
    input  wire logic [VW-1:0]            i_idx,
    input  wire logic signed [ELEM_W-1:0] i_val,
    input  wire logic signed [SUM_W-1:0]  i_diag,
    output logic                          o_valid,
    output logic      [VW-1:0]            o_idx,
    output logic signed [ELEM_W-1:0]      o_val,
    output logic signed [SUM_W-1:0]       o_diag,
    output logic signed [SUM_W-1:0]       o_score,
    input  wire logic [VW-1:0]            i_tb_addr,
    output logic                          o_take
);
    logic signed [ELEM_W-1:0] r_coef;
    logic                     r_valid;
    logic [VW-1:0]            r_idx;
    logic signed [ELEM_W-1:0] r_val;
    logic signed [SUM_W-1:0]  r_prev;
    logic signed [SUM_W-1:0]  r_score;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_cand;
    logic                     w_active;
    logic                     w_take;

    // row K covers value indexes K .. K + (n - m)
    assign w_active = i_valid && (32'(i_idx) >= K) && ((32'(i_idx) - K) <= 32'(i_span));
    assign w_prod   = r_coef * i_val;
    assign w_cand   = SUM_W'(w_prod) + i_diag;
    assign w_take   = (32'(i_idx) == K) || (w_cand > r_score);

    always_ff @(posedge i_clk) begin
        if (i_coef_we && (32'(i_coef_pos) == K)) begin
            r_coef <= i_coef;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_idx <= i_idx;
        r_val <= i_val;
        if (i_valid) begin
            r_prev <= r_score;
        end
        if (w_active && w_take) begin
            r_score <= w_cand;
        end
    end

    osmpd_ram #(.WIDTH(1), .DEPTH(MAX_VALUES)) u_take (
        .i_clk   (i_clk),
        .i_we    (w_active),
        .i_waddr (i_idx),
        .i_wdata (w_take),
        .i_raddr (i_tb_addr),
        .o_rdata (o_take)
    );

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_val   = r_val;
    assign o_diag  = r_prev;
    assign o_score = r_score;
endmodule
`default_nettype wire
